FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dvdd_pkg.sv
// ----------------------------------------------------------------------------
// dvdd_pkg
// Types, constants and calendar tables for the date distance unit.
// ----------------------------------------------------------------------------
package dvdd_pkg;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MON_W    = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned DOY_W    = 9;
    localparam int unsigned REM_W    = 9;
    localparam int unsigned ACC_W    = 23;
    localparam int unsigned TOTAL_W  = 22;
    localparam int unsigned AYEARS_W = 14;
    localparam int unsigned AMON_W   = 4;
    localparam int unsigned ADAYS_W  = 5;
    localparam int unsigned IN_W     = 48;
    localparam int unsigned OUT_W    = 48;
    localparam int unsigned USER_W   = 2;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    // reciprocal division, exact over the operand ranges used here
    localparam int unsigned Q400_P_W = 22;
    localparam int unsigned Q400_SH  = 16;
    localparam int unsigned Q365_P_W = 44;
    localparam int unsigned Q365_SH  = 30;
    localparam int unsigned Q30_P_W  = 17;
    localparam int unsigned Q30_SH   = 12;

    localparam logic [11:0] RCP_25  = 12'd2622;     // ceil(2^16 / 25)
    localparam logic [21:0] RCP_365 = 22'd2941759;  // ceil(2^30 / 365)
    localparam logic [8:0]  RCP_15  = 9'd274;       // ceil(2^12 / 15)

    localparam logic [TOTAL_W-1:0] DAYS_LIMIT  = {TOTAL_W{1'b1}};
    localparam logic [YEAR_W-1:0]  YEAR_CYCLE  = 14'd400;
    localparam logic [REM_W-1:0]   M400_LAST   = 9'd399;
    localparam logic [ACC_W-1:0]   DAYS_YEAR   = 23'd365;
    localparam logic [TOTAL_W-1:0] YEAR_DAYS_T = 22'd365;
    localparam logic [REM_W-1:0]   YEAR_DAYS_R = 9'd365;
    localparam logic [REM_W-1:0]   MONTH_DAYS  = 9'd30;
    localparam logic [MON_W-1:0]   MON_FEB     = 4'd2;
    localparam logic [MON_W-1:0]   MON_DEC     = 4'd12;

    typedef struct packed {
        logic capture;
        logic save_mod;
        logic check;
        logic yr_step;
        logic finish;
        logic split_yrs;
        logic split_rem;
        logic split_md;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic chk_ok;
        logic year_eq;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // days in the months before m, common year
    function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // leap test from year mod 400
    function automatic logic leap400(input logic [REM_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    // year mod 400 via floor((year / 16) / 25)
    function automatic logic [REM_W-1:0] mod400(input logic [YEAR_W-1:0] y);
        logic [Q400_P_W-1:0] prod;
        logic [YEAR_W-1:0]   q;
        logic [YEAR_W-1:0]   r;
        prod = Q400_P_W'(y[YEAR_W-1:4]) * Q400_P_W'(RCP_25);
        q    = YEAR_W'(prod[Q400_P_W-1:Q400_SH]);
        r    = y - q * YEAR_CYCLE;
        return r[REM_W-1:0];
    endfunction

endpackage

FILE: rtl/dvdd_ctrl.sv
// ----------------------------------------------------------------------------
// dvdd_ctrl
// Sequencer: year mods, validation, year walk, splitting, result hand-off.
// ----------------------------------------------------------------------------
module dvdd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  dvdd_pkg::dp_stat_t stat,
    output dvdd_pkg::dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MOD  = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_YRS  = 8'b0000_1000,
        S_QY   = 8'b0001_0000,
        S_QR   = 8'b0010_0000,
        S_QM   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.save_mod = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.chk_ok ? S_YRS : S_DONE;
            end
            S_YRS:
            begin
                if (stat.year_eq)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_QY;
                end
                else
                begin
                    cmd.yr_step = 1'b1;
                end
            end
            S_QY:
            begin
                cmd.split_yrs = 1'b1;
                state_next    = S_QR;
            end
            S_QR:
            begin
                cmd.split_rem = 1'b1;
                state_next    = S_QM;
            end
            S_QM:
            begin
                cmd.split_md = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/dvdd_dp.sv
// ----------------------------------------------------------------------------
// dvdd_dp
// Datapath: input capture, date checks, year accumulator, reciprocal
// splits by 365 and 30, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvdd_dp
#(
    parameter int unsigned MAX_YEAR = dvdd_pkg::MAX_YEAR_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dvdd_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [dvdd_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic [dvdd_pkg::USER_W-1:0]  m_axis_tuser,
    input  dvdd_pkg::dp_cmd_t            cmd,
    output dvdd_pkg::dp_stat_t           stat
);

    localparam logic [dvdd_pkg::YEAR_W-1:0] MAX_YEAR_V = dvdd_pkg::YEAR_W'(MAX_YEAR);
    localparam int unsigned OUT_PAD = dvdd_pkg::OUT_W - dvdd_pkg::TOTAL_W
                                      - dvdd_pkg::AYEARS_W - dvdd_pkg::AMON_W
                                      - dvdd_pkg::ADAYS_W;

    logic [dvdd_pkg::DAY_W-1:0]    sd_reg, sd_next, ed_reg, ed_next;
    logic [dvdd_pkg::MON_W-1:0]    sm_reg, sm_next, em_reg, em_next;
    logic [dvdd_pkg::YEAR_W-1:0]   sy_reg, sy_next, ey_reg, ey_next;
    logic [dvdd_pkg::REM_W-1:0]    m400s_reg, m400s_next, m400e_reg, m400e_next;
    logic [dvdd_pkg::REM_W-1:0]    m400c_reg, m400c_next;
    logic [dvdd_pkg::YEAR_W-1:0]   year_reg, year_next;
    logic [dvdd_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                          valid_reg, valid_next, order_reg, order_next;
    logic [dvdd_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [dvdd_pkg::AYEARS_W-1:0] yrs_reg, yrs_next;
    logic [dvdd_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [dvdd_pkg::AMON_W-1:0]   mon_reg, mon_next;
    logic [dvdd_pkg::ADAYS_W-1:0]  days_reg, days_next;
    logic                          out_valid_reg, out_valid_next;
    logic [dvdd_pkg::OUT_W-1:0]    out_data_reg, out_data_next;
    logic [dvdd_pkg::USER_W-1:0]   out_user_reg, out_user_next;

    logic                          leap_s, leap_e, leap_c;
    logic [dvdd_pkg::DAY_W-1:0]    lim_s, lim_e;
    logic                          ok_s, ok_e, after;
    logic [dvdd_pkg::DOY_W-1:0]    doy_s, doy_e;
    logic [dvdd_pkg::ACC_W-1:0]    diff;
    logic [dvdd_pkg::Q365_P_W-1:0] q365_prod;
    logic [dvdd_pkg::TOTAL_W-1:0]  rem_wide;
    logic [dvdd_pkg::Q30_P_W-1:0]  q30_prod;
    logic [dvdd_pkg::AMON_W-1:0]   q30;
    logic [dvdd_pkg::REM_W-1:0]    days_wide;

    // date checks and split arithmetic
    always_comb
    begin
        leap_s = dvdd_pkg::leap400(m400s_reg);
        leap_e = dvdd_pkg::leap400(m400e_reg);
        leap_c = dvdd_pkg::leap400(m400c_reg);
        lim_s  = dvdd_pkg::month_len(sm_reg)
                 + dvdd_pkg::DAY_W'((sm_reg == dvdd_pkg::MON_FEB) && leap_s);
        lim_e  = dvdd_pkg::month_len(em_reg)
                 + dvdd_pkg::DAY_W'((em_reg == dvdd_pkg::MON_FEB) && leap_e);
        ok_s   = (sy_reg != '0) && (sy_reg <= MAX_YEAR_V) && (sm_reg != '0)
                 && (sm_reg <= dvdd_pkg::MON_DEC) && (sd_reg != '0) && (sd_reg <= lim_s);
        ok_e   = (ey_reg != '0) && (ey_reg <= MAX_YEAR_V) && (em_reg != '0)
                 && (em_reg <= dvdd_pkg::MON_DEC) && (ed_reg != '0) && (ed_reg <= lim_e);
        after  = {sy_reg, sm_reg, sd_reg} > {ey_reg, em_reg, ed_reg};
        doy_s  = dvdd_pkg::cum_days(sm_reg)
                 + dvdd_pkg::DOY_W'((sm_reg > dvdd_pkg::MON_FEB) && leap_s)
                 + dvdd_pkg::DOY_W'(sd_reg);
        doy_e  = dvdd_pkg::cum_days(em_reg)
                 + dvdd_pkg::DOY_W'((em_reg > dvdd_pkg::MON_FEB) && leap_e)
                 + dvdd_pkg::DOY_W'(ed_reg);
        diff   = acc_reg - dvdd_pkg::ACC_W'(doy_s);

        q365_prod = dvdd_pkg::Q365_P_W'(total_reg) * dvdd_pkg::Q365_P_W'(dvdd_pkg::RCP_365);
        rem_wide  = total_reg - dvdd_pkg::TOTAL_W'(yrs_reg) * dvdd_pkg::YEAR_DAYS_T;
        q30_prod  = dvdd_pkg::Q30_P_W'(rem_reg[dvdd_pkg::REM_W-1:1])
                    * dvdd_pkg::Q30_P_W'(dvdd_pkg::RCP_15);
        q30       = q30_prod[dvdd_pkg::Q30_SH+dvdd_pkg::AMON_W-1:dvdd_pkg::Q30_SH];
        days_wide = rem_reg - dvdd_pkg::REM_W'(q30) * dvdd_pkg::MONTH_DAYS;
    end

    assign stat.chk_ok   = ok_s && ok_e && !after;
    assign stat.year_eq  = (year_reg == ey_reg);
    assign stat.out_busy = out_valid_reg && !m_axis_tready;

    always_comb
    begin
        sd_next        = sd_reg;
        sm_next        = sm_reg;
        sy_next        = sy_reg;
        ed_next        = ed_reg;
        em_next        = em_reg;
        ey_next        = ey_reg;
        m400s_next     = m400s_reg;
        m400e_next     = m400e_reg;
        m400c_next     = m400c_reg;
        year_next      = year_reg;
        acc_next       = acc_reg;
        valid_next     = valid_reg;
        order_next     = order_reg;
        total_next     = total_reg;
        yrs_next       = yrs_reg;
        rem_next       = rem_reg;
        mon_next       = mon_reg;
        days_next      = days_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (cmd.capture)
        begin
            sd_next = s_axis_tdata[4:0];
            sm_next = s_axis_tdata[8:5];
            sy_next = s_axis_tdata[22:9];
            ed_next = s_axis_tdata[27:23];
            em_next = s_axis_tdata[31:28];
            ey_next = s_axis_tdata[45:32];
        end

        if (cmd.save_mod)
        begin
            m400s_next = dvdd_pkg::mod400(sy_reg);
            m400e_next = dvdd_pkg::mod400(ey_reg);
        end

        if (cmd.check)
        begin
            valid_next = ok_s && ok_e;
            order_next = ok_s && ok_e && after;
            acc_next   = dvdd_pkg::ACC_W'(doy_e);
            year_next  = sy_reg;
            m400c_next = m400s_reg;
        end

        if (cmd.yr_step)
        begin
            acc_next   = acc_reg + dvdd_pkg::DAYS_YEAR + dvdd_pkg::ACC_W'(leap_c);
            year_next  = year_reg + 1'b1;
            m400c_next = (m400c_reg == dvdd_pkg::M400_LAST) ? '0 : m400c_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            total_next = (diff > dvdd_pkg::ACC_W'(dvdd_pkg::DAYS_LIMIT))
                         ? dvdd_pkg::DAYS_LIMIT : diff[dvdd_pkg::TOTAL_W-1:0];
        end
        if (cmd.split_yrs)
        begin
            yrs_next = q365_prod[dvdd_pkg::Q365_SH+dvdd_pkg::AYEARS_W-1:dvdd_pkg::Q365_SH];
        end
        if (cmd.split_rem)
        begin
            rem_next = rem_wide[dvdd_pkg::REM_W-1:0];
        end
        if (cmd.split_md)
        begin
            mon_next  = q30;
            days_next = days_wide[dvdd_pkg::ADAYS_W-1:0];
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_user_next  = {order_reg, valid_reg};
            out_data_next  = (valid_reg && !order_reg)
                             ? {{OUT_PAD{1'b0}}, days_reg, mon_reg, yrs_reg, total_reg}
                             : '0;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sd_reg       <= sd_next;
        sm_reg       <= sm_next;
        sy_reg       <= sy_next;
        ed_reg       <= ed_next;
        em_reg       <= em_next;
        ey_reg       <= ey_next;
        m400s_reg    <= m400s_next;
        m400e_reg    <= m400e_next;
        m400c_reg    <= m400c_next;
        year_reg     <= year_next;
        acc_reg      <= acc_next;
        valid_reg    <= valid_next;
        order_reg    <= order_next;
        total_reg    <= total_next;
        yrs_reg      <= yrs_next;
        rem_reg      <= rem_next;
        mon_reg      <= mon_next;
        days_reg     <= days_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `AST_IMP(a_out_no_overrun, cmd.out_load, !(out_valid_reg && !m_axis_tready),
             "result overwritten before taken")
    `AST_IMP(a_year_walk_bound, cmd.yr_step, year_reg != ey_reg, "year walk past end year")
    `AST_IMP(a_rem_range, cmd.split_md, rem_reg < dvdd_pkg::YEAR_DAYS_R,
             "year remainder out of range")
    `AST_NXT(a_out_hold, out_valid_reg && !m_axis_tready,
             out_valid_reg && $stable(out_data_reg) && $stable(out_user_reg),
             "result changed while stalled")

endmodule

FILE: rtl/date_validate_and_day_distance_unit.sv
// ----------------------------------------------------------------------------
// date_validate_and_day_distance_unit
// Validates two Gregorian dates and counts the days between them.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word holds a start and an end date. It is taken
// only while the unit is idle; one word is worked on at a time.
// Output stream m_axis: one result word per input word, tuser carries the
// validity and order flags; total and split are zero unless both dates are
// valid and in order.
// From acceptance to m_axis_tvalid the sequencer runs year mod 400, check,
// one walk step per year from start year to end year, walk exit, the
// three splits (years by reciprocal, year remainder, months and days by
// reciprocal) and the result load. Rejected or reversed dates skip
// walk and splits. The next word can be taken in the cycle after the
// result load.
// The result sits in an output register: the next input word is accepted
// while it waits; a stalled receiver holds the sequencer in its final step.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module date_validate_and_day_distance_unit
#(
    parameter int unsigned MAX_YEAR = dvdd_pkg::MAX_YEAR_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year
    input  logic [dvdd_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // total_days, approx_years, approx_months, approx_days
    output logic [dvdd_pkg::OUT_W-1:0]   m_axis_tdata,
    // dates_valid, order_error
    output logic [dvdd_pkg::USER_W-1:0]  m_axis_tuser
);

    dvdd_pkg::dp_cmd_t  cmd;
    dvdd_pkg::dp_stat_t stat;

    dvdd_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    dvdd_dp
    #(
        .MAX_YEAR (MAX_YEAR)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

FILE: verif/tb_date_validate_and_day_distance_unit.sv
// ----------------------------------------------------------------------------
// tb_date_validate_and_day_distance_unit
// Self-checking bench for the Gregorian day distance unit: each date pair
// sent is predicted in the bench and the result word is checked field by
// field. Directed corner dates come first, then random pairs under varying
// back-pressure, including one long output stall.
// ----------------------------------------------------------------------------
module tb_date_validate_and_day_distance_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned YEAR_CAP     = dvdd_pkg::MAX_YEAR_DEF;
    localparam int unsigned RANDOM_WORDS = 78;
    localparam int unsigned HOLD_CYCLES  = 2500;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned REPORT_MAX   = 10;

    typedef struct packed {
        logic [dvdd_pkg::ADAYS_W-1:0]  days;
        logic [dvdd_pkg::AMON_W-1:0]   months;
        logic [dvdd_pkg::AYEARS_W-1:0] years;
        logic [dvdd_pkg::TOTAL_W-1:0]  total;
        logic                          order_error;
        logic                          dates_valid;
    } span_t;

    class day_span_board;
        span_t       expected_spans[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned n_spans;
        int unsigned n_reversed;
        int unsigned n_rejected;
        int unsigned longest;

        function new();
            mismatches = 0;
            checked    = 0;
            n_spans    = 0;
            n_reversed = 0;
            n_rejected = 0;
            longest    = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int unsigned days_in_month(int unsigned m, int unsigned y);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function bit date_legal(int unsigned d, int unsigned m, int unsigned y);
            if (y < 1 || y > YEAR_CAP)
                return 1'b0;
            if (m < 1 || m > 12)
                return 1'b0;
            return (d >= 1) && (d <= days_in_month(m, y));
        endfunction

        static function longint unsigned day_number(int unsigned d, int unsigned m,
                                                    int unsigned y);
            longint unsigned p;
            longint unsigned n;
            p = y - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400;
            for (int unsigned i = 1; i < m; i++)
                n += days_in_month(i, y);
            return n + d;
        endfunction

        function void note_dates(logic [dvdd_pkg::IN_W-1:0] w);
            int unsigned     sd, sm, sy, ed, em, ey;
            longint unsigned a, b, total, rem;
            span_t           e;
            sd = w[4:0];
            sm = w[8:5];
            sy = w[22:9];
            ed = w[27:23];
            em = w[31:28];
            ey = w[45:32];
            e  = '0;
            if (!date_legal(sd, sm, sy) || !date_legal(ed, em, ey))
            begin
                n_rejected++;
            end
            else
            begin
                e.dates_valid = 1'b1;
                a = day_number(sd, sm, sy);
                b = day_number(ed, em, ey);
                if (a > b)
                begin
                    e.order_error = 1'b1;
                    n_reversed++;
                end
                else
                begin
                    total = b - a;
                    if (total > dvdd_pkg::DAYS_LIMIT)
                        total = dvdd_pkg::DAYS_LIMIT;
                    rem      = total % 365;
                    e.total  = total[dvdd_pkg::TOTAL_W-1:0];
                    e.years  = dvdd_pkg::AYEARS_W'(total / 365);
                    e.months = dvdd_pkg::AMON_W'(rem / 30);
                    e.days   = dvdd_pkg::ADAYS_W'(rem % 30);
                    n_spans++;
                    if (total > longest)
                        longest = int'(total);
                end
            end
            expected_spans.push_back(e);
        endfunction

        function void check_span(logic [dvdd_pkg::OUT_W-1:0] data,
                                 logic [dvdd_pkg::USER_W-1:0] user);
            span_t got;
            span_t e;
            got.dates_valid = user[0];
            got.order_error = user[1];
            got.total       = data[21:0];
            got.years       = data[35:22];
            got.months      = data[39:36];
            got.days        = data[44:40];
            checked++;
            if (expected_spans.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word: valid=%0b order=%0b total=%0d",
                             got.dates_valid, got.order_error, got.total);
                return;
            end
            e = expected_spans.pop_front();
            if (got.dates_valid !== e.dates_valid || got.order_error !== e.order_error ||
                got.total !== e.total || got.years !== e.years ||
                got.months !== e.months || got.days !== e.days)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"mismatch: exp valid=%0b order=%0b total=%0d y=%0d m=%0d ",
                              "d=%0d / got valid=%0b order=%0b total=%0d y=%0d m=%0d d=%0d"},
                             e.dates_valid, e.order_error, e.total, e.years, e.months,
                             e.days, got.dates_valid, got.order_error, got.total,
                             got.years, got.months, got.days);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [dvdd_pkg::IN_W-1:0]     s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [dvdd_pkg::OUT_W-1:0]    m_axis_tdata;
    logic [dvdd_pkg::USER_W-1:0]   m_axis_tuser;

    day_span_board board;
    int unsigned   send_idle;
    int unsigned   recv_idle;
    bit            hold_request;

    date_validate_and_day_distance_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [dvdd_pkg::IN_W-1:0] pack_dates(int unsigned sd,
                                                             int unsigned sm,
                                                             int unsigned sy,
                                                             int unsigned ed,
                                                             int unsigned em,
                                                             int unsigned ey);
        return {2'b00, 14'(ey), 4'(em), 5'(ed), 14'(sy), 4'(sm), 5'(sd)};
    endfunction

    // mostly legal pairs up to 30 years apart; some far apart, some reversed,
    // some raw noise
    function automatic logic [dvdd_pkg::IN_W-1:0] random_word();
        int unsigned pick, sd, sm, sy, ed, em, ey;
        pick = $urandom_range(99);
        if (pick < 18)
            return pack_dates($urandom & 32'h1f, $urandom & 32'hf, $urandom & 32'h3fff,
                              $urandom & 32'h1f, $urandom & 32'hf, $urandom & 32'h3fff);
        sy = $urandom_range(YEAR_CAP, 1);
        if (pick < 23)
        begin
            ey = $urandom_range(YEAR_CAP, 1);
        end
        else
        begin
            ey = sy + $urandom_range(30);
            if (ey > YEAR_CAP)
                ey = YEAR_CAP;
        end
        sm = $urandom_range(12, 1);
        em = (pick < 40) ? sm : $urandom_range(12, 1);
        sd = $urandom_range(day_span_board::days_in_month(sm, sy), 1);
        ed = $urandom_range(day_span_board::days_in_month(em, ey), 1);
        if (pick >= 90)
            return pack_dates(ed, em, ey, sd, sm, sy);
        return pack_dates(sd, sm, sy, ed, em, ey);
    endfunction

    task automatic send_word(logic [dvdd_pkg::IN_W-1:0] w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_dates(w);
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
    endtask

    initial
    begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_span(m_axis_tdata, m_axis_tuser);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial
    begin
        #150ms;
        $display("timeout waiting for results");
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        board         = new();
        send_idle     = 12;
        recv_idle     = 76;
        hold_request  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(pack_dates(1, 1, 1, 31, 12, 9999));
        send_word(pack_dates(31, 12, 9999, 1, 1, 1));
        send_word(pack_dates(15, 6, 2000, 15, 6, 2000));
        send_word(pack_dates(2, 1, 2000, 1, 1, 2000));
        send_word(pack_dates(0, 0, 0, 0, 0, 0));
        send_word(pack_dates(31, 15, 16383, 31, 15, 16383));
        send_word(pack_dates(0, 3, 2010, 5, 3, 2010));
        send_word(pack_dates(1, 13, 2010, 5, 3, 2011));
        send_word(pack_dates(1, 1, 2010, 1, 15, 2011));
        send_word(pack_dates(1, 1, 0, 1, 1, 5));
        send_word(pack_dates(1, 1, 9999, 1, 1, 10000));
        send_word(pack_dates(31, 4, 2020, 1, 5, 2020));
        send_word(pack_dates(29, 2, 2000, 1, 3, 2000));
        send_word(pack_dates(29, 2, 1900, 1, 3, 1900));
        send_word(pack_dates(29, 2, 2004, 28, 2, 2005));
        send_word(pack_dates(1, 1, 2001, 29, 2, 2001));
        send_word(pack_dates(28, 2, 2023, 1, 3, 2024));
        send_word(pack_dates(31, 12, 1999, 1, 1, 2000));
        send_word(pack_dates(1, 1, 1, 2, 1, 1));
        send_word(pack_dates(1, 1, 1600, 31, 12, 2400));
        send_word(pack_dates(10, 10, 1010, 10, 10, 1011));
        send_word(pack_dates(5, 5, 500, 31, 5, 500));

        for (int unsigned i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 3)
            begin
                send_idle = 76;
                recv_idle = 12;
            end
            if (i == 2 * RANDOM_WORDS / 3)
            begin
                send_idle    = 0;
                recv_idle    = 0;
                hold_request = 1'b1;
            end
            send_word(random_word());
        end
        s_axis_tvalid <= 1'b0;

        while (board.expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d results: %0d spans, %0d reversed, %0d rejected dates",
                 board.checked, board.n_spans, board.n_reversed, board.n_rejected);
        $display("longest span %0d days, %0d mismatches, one %0d-cycle output stall",
                 board.longest, board.mismatches, HOLD_CYCLES);
        if (board.mismatches == 0 && board.expected_spans.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
